@@ design/lkvc_pkg.sv @@
// ============================================================================
// lkvc_pkg
// Shared sizes, codes and types for the LRU key-value cache.
// ============================================================================
package lkvc_pkg;

    // entry count and derived widths
    localparam int ENTRIES = 16;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int CFG_W   = 5;
    localparam int CMP_W   = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int WORD_W  = 32;

    localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(16);

    // request codes
    localparam logic OP_GET = 1'b0;
    localparam logic OP_SET = 1'b1;

    typedef logic signed [WORD_W-1:0] t_word;

    localparam t_word MISS_VALUE = '1;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_MATCH  = 3'b010,
        S_COMMIT = 3'b100
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic match;
        logic commit;
    } t_dp_cmd;

endpackage

@@ design/lkvc_ctrl.sv @@
// ============================================================================
// lkvc_ctrl
// Request sequencer: capture, match, commit, plus the result valid flag.
// ============================================================================
module lkvc_ctrl
    import lkvc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    output t_dp_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    // result register can take a new result this cycle
    assign out_free = !r_out_valid || !i_out_stall;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_MATCH;
                end
            end
            S_MATCH: begin
                o_cmd.match = 1'b1;
                n_state     = S_COMMIT;
            end
            S_COMMIT: begin
                if (out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // result valid: set on commit, cleared once taken
    assign n_out_valid = o_cmd.commit || (r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

@@ design/lkvc_dp.sv @@
// ============================================================================
// lkvc_dp
// Entry stores, parallel key match, victim pick, recency update, result reg.
// ============================================================================
module lkvc_dp
    import lkvc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_dp_cmd          i_cmd,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_operation,
    input  t_word            i_lookup_key,
    input  t_word            i_write_value,
    output logic             o_hit,
    output t_word            o_read_value,
    output logic             o_evicted
);

    // entry state
    t_word              r_key  [ENTRIES];
    t_word              r_val  [ENTRIES];
    logic [IDX_W-1:0]   r_rank [ENTRIES];
    logic [ENTRIES-1:0] r_valid;
    logic [CNT_W-1:0]   r_count;
    logic [CFG_W-1:0]   r_cap;

    // captured request
    logic               r_op;
    t_word              r_req_key;
    t_word              r_req_val;

    // match results
    logic               r_found;
    logic [IDX_W-1:0]   r_found_idx;
    logic [IDX_W-1:0]   r_found_rank;
    logic               r_evict;
    logic [IDX_W-1:0]   r_slot;

    // result register
    logic               r_hit;
    t_word              r_rd;
    logic               r_ev;

    logic [ENTRIES-1:0] match_vec;
    logic [ENTRIES-1:0] victim_vec;
    logic [ENTRIES-1:0] free_vec;
    logic [IDX_W-1:0]   match_idx;
    logic [IDX_W-1:0]   victim_idx;
    logic [IDX_W-1:0]   free_idx;
    logic [IDX_W-1:0]   oldest_rank;
    logic [CMP_W-1:0]   cap_ext;
    logic [CMP_W-1:0]   eff_cap;
    logic               evict_now;

    // lowest set bit of a vector
    function automatic logic [IDX_W-1:0] first_set(input logic [ENTRIES-1:0] vec);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int k = ENTRIES - 1; k >= 0; k--) begin
            if (vec[k]) begin
                idx = IDX_W'(k);
            end
        end
        return idx;
    endfunction

    // parallel compare and victim search (ranks of valid entries are distinct)
    assign oldest_rank = IDX_W'(r_count - CNT_W'(1));

    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            match_vec[i]  = r_valid[i] && (r_key[i] == r_req_key);
            victim_vec[i] = r_valid[i] && (r_rank[i] == oldest_rank);
            free_vec[i]   = !r_valid[i];
        end
    end

    assign match_idx  = first_set(match_vec);
    assign victim_idx = first_set(victim_vec);
    assign free_idx   = first_set(free_vec);

    // capacity clamped to 1..ENTRIES
    assign cap_ext = CMP_W'(r_cap);
    always_comb begin
        if (cap_ext == '0) begin
            eff_cap = CMP_W'(1);
        end else if (cap_ext > CMP_W'(ENTRIES)) begin
            eff_cap = CMP_W'(ENTRIES);
        end else begin
            eff_cap = cap_ext;
        end
    end

    assign evict_now = (r_count != '0) && (CMP_W'(r_count) >= eff_cap);

    // capture and match registers (payload, no reset)
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op      <= i_operation;
            r_req_key <= i_lookup_key;
            r_req_val <= i_write_value;
        end
        if (i_cmd.match) begin
            r_found      <= |match_vec;
            r_found_idx  <= match_idx;
            r_found_rank <= r_rank[match_idx];
            r_evict      <= evict_now;
            r_slot       <= evict_now ? victim_idx : free_idx;
        end
    end

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (i_cfg_we) begin
            r_cap <= i_cfg_data;
        end
    end

    // commit: valid marks, ranks and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_rank[i] <= '0;
            end
        end else if (i_cmd.commit) begin
            if (r_found) begin
                // promote the hit entry
                for (int i = 0; i < ENTRIES; i++) begin
                    if (IDX_W'(i) == r_found_idx) begin
                        r_rank[i] <= '0;
                    end else if (r_valid[i] && (r_rank[i] < r_found_rank)) begin
                        r_rank[i] <= r_rank[i] + IDX_W'(1);
                    end
                end
            end else if (r_op == OP_SET) begin
                // insert as most recent, everything else ages
                for (int i = 0; i < ENTRIES; i++) begin
                    if (IDX_W'(i) == r_slot) begin
                        r_rank[i]  <= '0;
                        r_valid[i] <= 1'b1;
                    end else if (r_valid[i]) begin
                        r_rank[i] <= r_rank[i] + IDX_W'(1);
                    end
                end
                if (!r_evict) begin
                    r_count <= r_count + CNT_W'(1);
                end
            end
        end
    end

    // commit: key and value stores
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && (r_op == OP_SET)) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (r_found && (IDX_W'(i) == r_found_idx)) begin
                    r_val[i] <= r_req_val;
                end else if (!r_found && (IDX_W'(i) == r_slot)) begin
                    r_key[i] <= r_req_key;
                    r_val[i] <= r_req_val;
                end
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_hit <= r_found;
            r_ev  <= !r_found && (r_op == OP_SET) && r_evict;
            if (r_op == OP_SET) begin
                r_rd <= r_req_val;
            end else if (r_found) begin
                r_rd <= r_val[r_found_idx];
            end else begin
                r_rd <= MISS_VALUE;
            end
        end
    end

    assign o_hit        = r_hit;
    assign o_read_value = r_rd;
    assign o_evicted    = r_ev;

endmodule

@@ design/lru_key_value_cache.sv @@
// ============================================================================
// lru_key_value_cache
// Fully associative key-value cache with least-recently-used replacement.
// ============================================================================
// Each accepted request passes through capture, parallel key match and
//   commit through the single store update path before its result is
//   valid; the next request is held off until that commit, and longer
//   while a result waits on a stalled output.
// Reset (synchronous, active low): all entries invalid, live count zero,
//   capacity 16; usable on the next cycle.
module lru_key_value_cache
    import lkvc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic             i_operation,
    input  t_word            i_lookup_key,
    input  t_word            i_write_value,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic             o_hit,
    output t_word            o_read_value,
    output logic             o_evicted
);

    t_dp_cmd cmd;

    lkvc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    lkvc_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_operation   (i_operation),
        .i_lookup_key  (i_lookup_key),
        .i_write_value (i_write_value),
        .o_hit         (o_hit),
        .o_read_value  (o_read_value),
        .o_evicted     (o_evicted)
    );

    // an accepted request holds off the next one
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request accepted while another is in flight");

    // match always follows a capture
    a_match_after_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.match |-> $past(cmd.capture))
        else $error("match without captured request");

    // commit never overwrites a result still waiting
    a_commit_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |-> (!o_out_valid || !i_out_stall))
        else $error("result overwritten while stalled");

    // an eviction only happens on an insert, never on a hit
    a_evict_not_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_evicted) |-> !o_hit)
        else $error("eviction flagged on a hit");

endmodule

@@ sim/tb_lru_key_value_cache.sv @@
// ============================================================================
// tb_lru_key_value_cache
// Self-checking bench for the LRU key-value cache: a scoreboard keeps its own
// copy of the entries, ranks and capacity, predicts each response as a
// request is accepted, and checks responses in order. Directed corner cases
// come first, then random traffic over small key pools with several
// capacities, bursty requests, receiver stalls and one long output hold-off.
// ============================================================================
module tb_lru_key_value_cache;
    import lkvc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_LIMIT  = 5000;
    localparam int RUN_LIMIT_NS = 2000000;
    localparam int POOL_MAX     = 24;

    // expected response of one request
    typedef struct {
        logic  hit;
        t_word read_value;
        logic  evicted;
    } t_cache_resp;

    // cache model plus queue of pending responses
    class cache_scoreboard;
        logic [WORD_W-1:0] key_mem [ENTRIES];
        logic [WORD_W-1:0] val_mem [ENTRIES];
        logic              live    [ENTRIES];
        logic [IDX_W-1:0]  rank    [ENTRIES];
        int                occupancy;
        logic [CFG_W-1:0]  capacity;
        t_cache_resp       pending_resps [$];
        int                failures;

        function new();
            for (int i = 0; i < ENTRIES; i++) begin
                live[i] = 1'b0;
                rank[i] = '0;
            end
            occupancy = 0;
            capacity  = CAP_RESET;
            failures  = 0;
        endfunction

        function void set_capacity(logic [CFG_W-1:0] value);
            capacity = value;
        endfunction

        function int limit();
            int c;
            c = int'(capacity);
            if (c == 0) c = 1;
            if (c > ENTRIES) c = ENTRIES;
            return c;
        endfunction

        // entries more recent than s age by one, s becomes most recent
        function void promote(int s);
            logic [IDX_W-1:0] r;
            r = rank[s];
            for (int i = 0; i < ENTRIES; i++)
                if (live[i] && rank[i] < r) rank[i] = rank[i] + 1'b1;
            rank[s] = '0;
        endfunction

        function void note_request(logic op, t_word key, t_word wval);
            int               found;
            int               slot;
            logic [IDX_W-1:0] oldest;
            t_cache_resp      resp;
            found = -1;
            slot  = -1;
            oldest = '0;
            for (int i = 0; i < ENTRIES; i++)
                if (found < 0 && live[i] && key_mem[i] == key) found = i;
            resp.hit     = (found >= 0);
            resp.evicted = 1'b0;
            if (op == OP_GET) begin
                if (found >= 0) begin
                    resp.read_value = val_mem[found];
                    promote(found);
                end else begin
                    resp.read_value = MISS_VALUE;
                end
            end else begin
                resp.read_value = wval;
                if (found >= 0) begin
                    val_mem[found] = wval;
                    promote(found);
                end else begin
                    // full: drop the least recent entry first
                    if (occupancy >= limit() && occupancy > 0) begin
                        for (int i = 0; i < ENTRIES; i++)
                            if (live[i] && (slot < 0 || rank[i] > oldest)) begin
                                slot   = i;
                                oldest = rank[i];
                            end
                        if (slot >= 0) begin
                            live[slot] = 1'b0;
                            occupancy--;
                            resp.evicted = 1'b1;
                        end
                    end
                    if (slot < 0)
                        for (int i = 0; i < ENTRIES; i++)
                            if (slot < 0 && !live[i]) slot = i;
                    if (slot >= 0) begin
                        for (int i = 0; i < ENTRIES; i++)
                            if (live[i]) rank[i] = rank[i] + 1'b1;
                        key_mem[slot] = key;
                        val_mem[slot] = wval;
                        live[slot]    = 1'b1;
                        rank[slot]    = '0;
                        occupancy++;
                    end
                end
            end
            pending_resps.push_back(resp);
        endfunction

        function void check_response(logic hit, t_word rd, logic ev);
            t_cache_resp exp_resp;
            if (pending_resps.size() == 0) begin
                $display("%0t ERROR response with no request pending: hit %0b value %h evicted %0b",
                         $time, hit, rd, ev);
                failures++;
                return;
            end
            exp_resp = pending_resps.pop_front();
            if (hit !== exp_resp.hit) begin
                $display("%0t ERROR hit: expected %0b actual %0b", $time, exp_resp.hit, hit);
                failures++;
            end
            if (rd !== exp_resp.read_value) begin
                $display("%0t ERROR read_value: expected %h actual %h",
                         $time, exp_resp.read_value, rd);
                failures++;
            end
            if (ev !== exp_resp.evicted) begin
                $display("%0t ERROR evicted: expected %0b actual %0b",
                         $time, exp_resp.evicted, ev);
                failures++;
            end
        endfunction

        function void report_leftovers();
            if (pending_resps.size() != 0) begin
                $display("%0t ERROR %0d responses never arrived", $time, pending_resps.size());
                failures++;
            end
        endfunction
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CFG_W-1:0] i_cfg_data;
    logic             i_in_valid;
    logic             o_in_stall;
    logic             i_operation;
    t_word            i_lookup_key;
    t_word            i_write_value;
    logic             o_out_valid;
    logic             i_out_stall;
    logic             o_hit;
    t_word            o_read_value;
    logic             o_evicted;

    cache_scoreboard sb = new();

    bit    hold_off_req = 1'b0;
    t_word key_pool [POOL_MAX];
    int    pool_n;
    int    burst_left = 0;

    lru_key_value_cache u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_operation   (i_operation),
        .i_lookup_key  (i_lookup_key),
        .i_write_value (i_write_value),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_hit         (o_hit),
        .o_read_value  (o_read_value),
        .o_evicted     (o_evicted)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #(RUN_LIMIT_NS);
        $display("FAILURE");
        $finish;
    end

    // response monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall)
            sb.check_response(o_hit, o_read_value, o_evicted);
    end

    // receiver stall pattern, with an occasional long hold-off
    initial begin
        int mode;
        int mode_left;
        int period;
        int tick;
        mode = 0;
        mode_left = 0;
        period = 2;
        tick = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_off_req = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(8, 64);
                    period    = $urandom_range(2, 6);
                end
                mode_left--;
                tick++;
                case (mode)
                    0: i_out_stall <= 1'b0;
                    1: i_out_stall <= ($urandom_range(0, 2) == 0);
                    2: i_out_stall <= ($urandom_range(0, 3) != 0);
                    default: i_out_stall <= ((tick % period) < (period / 2));
                endcase
            end
        end
    end

    // offer one request and hold it until accepted; returns at a falling edge
    task automatic send_request(logic op, t_word key, t_word wval);
        i_in_valid    <= 1'b1;
        i_operation   <= op;
        i_lookup_key  <= key;
        i_write_value <= wval;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_request(op, key, wval);
        @(negedge i_clk);
    endtask

    // stop offering and wait until every response has come back
    task automatic wait_drained();
        int waited;
        waited = 0;
        i_in_valid <= 1'b0;
        while (sb.pending_resps.size() != 0 && waited < DRAIN_LIMIT) begin
            @(negedge i_clk);
            waited++;
        end
    endtask

    // capacity write, only with the block idle
    task automatic write_capacity(logic [CFG_W-1:0] value);
        wait_drained();
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        sb.set_capacity(value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // new key pool a little larger than the capacity so hits and evictions mix
    task automatic refill_pool();
        pool_n = sb.limit() + $urandom_range(1, 6);
        if (pool_n > POOL_MAX) pool_n = POOL_MAX;
        for (int i = 0; i < POOL_MAX; i++) key_pool[i] = $urandom;
        if ($urandom_range(0, 1)) key_pool[0] = 32'h8000_0000;
        if ($urandom_range(0, 1)) key_pool[1] = 32'h7FFF_FFFF;
        if ($urandom_range(0, 1)) key_pool[2] = '1;
        if ($urandom_range(0, 1)) key_pool[3] = '0;
    endtask

    // random requests in bursts; no_gaps keeps the sender busy every cycle
    task automatic run_random(int count, bit no_gaps);
        logic  op;
        t_word key;
        int    gap;
        repeat (count) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 12);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if (!no_gaps && gap > 0) begin
                    i_in_valid <= 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
            end
            burst_left--;
            op  = $urandom_range(0, 1);
            key = ($urandom_range(0, 9) < 8) ? key_pool[$urandom_range(0, pool_n - 1)]
                                             : t_word'($urandom);
            send_request(op, key, t_word'($urandom));
        end
    endtask

    // main sequence
    initial begin
        logic [CFG_W-1:0] caps [11];
        caps = '{5'd16, 5'd1, 5'd4, 5'd31, 5'd8, 5'd0, 5'd2, 5'd15, 5'd17, 5'd3, 5'd16};

        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_data    = '0;
        i_in_valid    = 1'b0;
        i_operation   = OP_GET;
        i_lookup_key  = '0;
        i_write_value = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: empty miss, extreme keys and values, update, all-ones hit
        send_request(OP_GET, 32'h0000_0000, 32'h1234_5678);
        send_request(OP_SET, 32'h8000_0000, 32'h7FFF_FFFF);
        send_request(OP_SET, 32'h7FFF_FFFF, 32'h8000_0000);
        send_request(OP_SET, 32'h0000_0000, 32'h0000_0000);
        send_request(OP_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(OP_GET, 32'h8000_0000, 32'h0);
        send_request(OP_GET, 32'hFFFF_FFFF, 32'h0);
        send_request(OP_SET, 32'h0000_0000, 32'h0000_007B);
        send_request(OP_GET, 32'h0000_0000, 32'hFFFF_FFFF);
        send_request(OP_GET, 32'h0000_0005, 32'h0);

        // capacity below the live count: each insert evicts exactly one
        write_capacity(5'd2);
        send_request(OP_SET, 32'h0000_000A, 32'hA5A5_A5A5);
        send_request(OP_SET, 32'h0000_000B, 32'h5A5A_5A5A);
        send_request(OP_GET, 32'h0000_000A, 32'h0);
        send_request(OP_GET, 32'h8000_0000, 32'h0);
        send_request(OP_GET, 32'hFFFF_FFFF, 32'h0);

        // capacity zero behaves as one
        write_capacity(5'd0);
        send_request(OP_SET, 32'h0000_0014, 32'h0000_0001);
        send_request(OP_SET, 32'h0000_0015, 32'h0000_0002);
        send_request(OP_GET, 32'h0000_0014, 32'h0);
        send_request(OP_GET, 32'h0000_0015, 32'h0);
        send_request(OP_SET, 32'h0000_0015, 32'h0000_0003);

        // capacity above the entry count saturates
        write_capacity(5'd31);
        send_request(OP_SET, 32'h0000_0016, 32'h0000_0004);
        send_request(OP_GET, 32'h0000_0015, 32'h0);

        // random phases over several capacities
        for (int p = 0; p < 11; p++) begin
            write_capacity(caps[p]);
            refill_pool();
            if (p == 4) begin
                // long output hold-off while the sender keeps offering
                hold_off_req = 1'b1;
                run_random(40, 1'b1);
            end else begin
                run_random(34, 1'b0);
            end
        end

        wait_drained();
        repeat (10) @(posedge i_clk);
        sb.report_leftovers();
        if (sb.failures == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
